>>> rtl/prq_pkg.sv
package prq_pkg;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef struct packed {
        logic enq;
        logic deq;
    } prq_op_t;

endpackage

>>> rtl/priority_ready_queue.sv
// Sorted priority queue of up to DEPTH entries (process id, priority), highest
// priority at the front and first in, first out among equal priorities. Every
// request, enqueue or dequeue, yields one result: each slot is a cell that
// compares its priority with the incoming one and shifts toward the back on
// insertion or toward the front on removal, so a new request is taken every
// cycle while the result register is free or being drained. A full enqueue
// is dropped with overflow set; an empty dequeue returns out_valid low.
module priority_ready_queue #(
    parameter int DEPTH          = 16,
    parameter int ID_WIDTH       = 8,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] proc_id,
    input  logic [7:0] priority_req,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       out_valid,
    output logic [7:0] out_id,
    output logic [7:0] out_priority,
    output logic [4:0] entry_count,
    output logic       overflow
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      res_valid_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [7:0]                out_id_reg;
    logic [7:0]                out_id_next;
    logic [7:0]                out_pri_reg;
    logic [7:0]                out_pri_next;
    logic [4:0]                count_out_reg;
    logic                      overflow_reg;
    logic                      overflow_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    prq_pkg::prq_op_t          op;

    logic [ID_WIDTH+7:0]       id_ext;
    logic [PRIORITY_WIDTH+7:0] pri_ext;
    logic [ID_WIDTH-1:0]       new_id;
    logic [PRIORITY_WIDTH-1:0] new_pri;
    logic [ID_WIDTH+7:0]       head_id_ext;
    logic [PRIORITY_WIDTH+7:0] head_pri_ext;
    logic [CW+4:0]             count_ext;

    logic [DEPTH-1:0]          ins;
    logic [DEPTH-1:0]          occupied;
    logic [ID_WIDTH-1:0]       cell_id  [DEPTH];
    logic [PRIORITY_WIDTH-1:0] cell_pri [DEPTH];

    assign accept = in_valid && in_ready;
    assign in_ready = !res_valid_reg || res_ready;
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign id_ext  = {{ID_WIDTH{1'b0}}, proc_id};
    assign pri_ext = {{PRIORITY_WIDTH{1'b0}}, priority_req};
    assign new_id  = id_ext[ID_WIDTH-1:0];
    assign new_pri = pri_ext[PRIORITY_WIDTH-1:0];

    assign op.enq = accept && (command == prq_pkg::CMD_ENQUEUE) && !full;
    assign op.deq = accept && (command == prq_pkg::CMD_DEQUEUE) && !empty;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                      left_ins;
            logic [ID_WIDTH-1:0]       left_id;
            logic [PRIORITY_WIDTH-1:0] left_pri;
            logic [ID_WIDTH-1:0]       right_id;
            logic [PRIORITY_WIDTH-1:0] right_pri;

            assign occupied[g] = (count_reg > CW'(g));

            if (g == 0)
            begin : g_first
                assign left_ins = 1'b0;
                assign left_id  = new_id;
                assign left_pri = new_pri;
            end
            else
            begin : g_mid
                assign left_ins = ins[g-1];
                assign left_id  = cell_id[g-1];
                assign left_pri = cell_pri[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_id  = cell_id[g];
                assign right_pri = cell_pri[g];
            end
            else
            begin : g_inner
                assign right_id  = cell_id[g+1];
                assign right_pri = cell_pri[g+1];
            end

            prq_cell #(
                .ID_WIDTH       (ID_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .clk       (clk),
                .op        (op),
                .occupied  (occupied[g]),
                .new_id    (new_id),
                .new_pri   (new_pri),
                .left_ins  (left_ins),
                .left_id   (left_id),
                .left_pri  (left_pri),
                .right_id  (right_id),
                .right_pri (right_pri),
                .ins       (ins[g]),
                .id        (cell_id[g]),
                .pri       (cell_pri[g])
            );
        end
    endgenerate

    assign head_id_ext  = {8'b0, cell_id[0]};
    assign head_pri_ext = {8'b0, cell_pri[0]};

    always_comb
    begin
        count_next = count_reg;
        if (op.enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.deq)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_ext = {5'b0, count_next};

    always_comb
    begin
        out_valid_next = 1'b0;
        out_id_next    = 8'b0;
        out_pri_next   = 8'b0;
        overflow_next  = 1'b0;
        case (command)
            prq_pkg::CMD_ENQUEUE:
            begin
                overflow_next = full;
            end
            prq_pkg::CMD_DEQUEUE:
            begin
                if (!empty)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = head_id_ext[7:0];
                    out_pri_next   = head_pri_ext[7:0];
                end
            end
            default:
            begin
                overflow_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_valid_reg <= out_valid_next;
            out_id_reg    <= out_id_next;
            out_pri_reg   <= out_pri_next;
            count_out_reg <= count_ext[4:0];
            overflow_reg  <= overflow_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_id       = out_id_reg;
    assign out_priority = out_pri_reg;
    assign entry_count  = count_out_reg;
    assign overflow     = overflow_reg;

endmodule

>>> rtl/prq_cell.sv
module prq_cell #(
    parameter int ID_WIDTH       = 8,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                      clk,
    input  prq_pkg::prq_op_t          op,
    input  logic                      occupied,
    input  logic [ID_WIDTH-1:0]       new_id,
    input  logic [PRIORITY_WIDTH-1:0] new_pri,
    input  logic                      left_ins,
    input  logic [ID_WIDTH-1:0]       left_id,
    input  logic [PRIORITY_WIDTH-1:0] left_pri,
    input  logic [ID_WIDTH-1:0]       right_id,
    input  logic [PRIORITY_WIDTH-1:0] right_pri,
    output logic                      ins,
    output logic [ID_WIDTH-1:0]       id,
    output logic [PRIORITY_WIDTH-1:0] pri
);

    logic [ID_WIDTH-1:0]       id_reg;
    logic [ID_WIDTH-1:0]       id_next;
    logic [PRIORITY_WIDTH-1:0] pri_reg;
    logic [PRIORITY_WIDTH-1:0] pri_next;

    // insertion point lies at or before this cell
    assign ins = !occupied || (pri_reg < new_pri);
    assign id  = id_reg;
    assign pri = pri_reg;

    always_comb
    begin
        id_next  = id_reg;
        pri_next = pri_reg;
        if (op.enq)
        begin
            if (left_ins)
            begin
                id_next  = left_id;
                pri_next = left_pri;
            end
            else if (ins)
            begin
                id_next  = new_id;
                pri_next = new_pri;
            end
        end
        else if (op.deq)
        begin
            id_next  = right_id;
            pri_next = right_pri;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        pri_reg <= pri_next;
    end

endmodule

>>> verif/tb_priority_ready_queue.sv
module tb_priority_ready_queue;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQUESTS = 1250;

    typedef struct {
        logic       cmd;
        logic [7:0] id;
        logic [7:0] pri;
        bit         drain;
        int         idle_pct;
        int         stall_pct;
    } queue_request_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] id;
        logic [7:0] pri;
        logic [4:0] count;
        logic       ovf;
    } queue_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       command = prq_pkg::CMD_ENQUEUE;
    logic [7:0] proc_id = 8'h00;
    logic [7:0] priority_req = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic       out_valid;
    logic [7:0] out_id;
    logic [7:0] out_priority;
    logic [4:0] entry_count;
    logic       overflow;

    queue_request_t pending_requests[$];
    queue_result_t  expected_responses[$];
    int             held_results = 0;
    int             stall_pct = 0;
    int             mismatch_count = 0;
    int             cycle_count = 0;

    logic [7:0]  model_id[DEPTH];
    logic [7:0]  model_pri[DEPTH];
    int unsigned model_count = 0;

    priority_ready_queue #(
        .DEPTH(DEPTH),
        .ID_WIDTH(8),
        .PRIORITY_WIDTH(8)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .proc_id(proc_id),
        .priority_req(priority_req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .out_valid(out_valid),
        .out_id(out_id),
        .out_priority(out_priority),
        .entry_count(entry_count),
        .overflow(overflow)
    );

    always #6 clk = ~clk;

    function automatic queue_result_t predict_queue_op(logic cmd, logic [7:0] id,
                                                       logic [7:0] pri);
        queue_result_t r;
        int            pos;
        int            i;
        bit            found;
        r = '0;
        if (cmd == prq_pkg::CMD_ENQUEUE)
        begin
            if (model_count >= DEPTH)
            begin
                r.ovf = 1'b1;
            end
            else
            begin
                pos = model_count;
                found = 1'b0;
                for (i = 0; i < model_count; i++)
                begin
                    if (!found && model_pri[i] < pri)
                    begin
                        pos = i;
                        found = 1'b1;
                    end
                end
                for (i = model_count; i > pos; i--)
                begin
                    model_id[i] = model_id[i - 1];
                    model_pri[i] = model_pri[i - 1];
                end
                model_id[pos] = id;
                model_pri[pos] = pri;
                model_count++;
            end
        end
        else if (model_count != 0)
        begin
            r.valid = 1'b1;
            r.id = model_id[0];
            r.pri = model_pri[0];
            for (i = 1; i < model_count; i++)
            begin
                model_id[i - 1] = model_id[i];
                model_pri[i - 1] = model_pri[i];
            end
            model_count--;
        end
        r.count = model_count[4:0];
        return r;
    endfunction

    task automatic add_request(logic cmd, logic [7:0] id, logic [7:0] pri, bit drain,
                               int idle_pct, int stall);
        queue_request_t q;
        q.cmd = cmd;
        q.id = id;
        q.pri = pri;
        q.drain = drain;
        q.idle_pct = idle_pct;
        q.stall_pct = stall;
        pending_requests.push_back(q);
    endtask

    function automatic logic [7:0] pick_priority();
        case ($urandom_range(3))
            0: return 8'($urandom_range(8'h43, 8'h40));
            1: return $urandom_range(1) ? 8'hff : 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_requests.size() != 0
                && !(pending_requests[0].drain && (held_results != 0 || in_valid))
                && $urandom_range(99) >= pending_requests[0].idle_pct)
            begin
                queue_request_t q;
                q = pending_requests.pop_front();
                in_valid <= 1'b1;
                command <= q.cmd;
                proc_id <= q.id;
                priority_req <= q.pri;
                stall_pct <= q.stall_pct;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        queue_result_t got;
        queue_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_responses.push_back(predict_queue_op(command, proc_id, priority_req));
            if (res_valid && res_ready)
            begin
                got = {out_valid, out_id, out_priority, entry_count, overflow};
                if (expected_responses.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: valid=%b id=%0d pri=%0d count=%0d ovf=%b",
                                 got.valid, got.id, got.pri, got.count, got.ovf);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (got.valid !== want.valid || got.id !== want.id
                        || got.pri !== want.pri || got.count !== want.count
                        || got.ovf !== want.ovf)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected valid=%b id=%0d pri=%0d count=%0d ",
                                      "ovf=%b, got valid=%b id=%0d pri=%0d count=%0d ovf=%b"},
                                     want.valid, want.id, want.pri, want.count, want.ovf,
                                     got.valid, got.id, got.pri, got.count, got.ovf);
                    end
                end
            end
            held_results <= expected_responses.size();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int  n;
        int  burst_left;
        int  enq_pct;
        int  idle;
        int  stall;
        int  phase;
        logic cmd;

        // empty dequeue, ties, extremes, fill to full, overflow
        add_request(prq_pkg::CMD_DEQUEUE, 8'hff, 8'hff, 1'b0, 0, 0);
        add_request(prq_pkg::CMD_ENQUEUE, 8'h00, 8'h00, 1'b0, 0, 0);
        add_request(prq_pkg::CMD_ENQUEUE, 8'hff, 8'hff, 1'b0, 0, 0);
        add_request(prq_pkg::CMD_ENQUEUE, 8'h01, 8'h80, 1'b0, 0, 0);
        add_request(prq_pkg::CMD_ENQUEUE, 8'h02, 8'h80, 1'b0, 0, 0);
        for (n = 0; n < 12; n++)
            add_request(prq_pkg::CMD_ENQUEUE, 8'(16 + n), 8'((n * 40) % 256), 1'b0, 0, 0);
        add_request(prq_pkg::CMD_ENQUEUE, 8'haa, 8'hff, 1'b0, 0, 0);
        add_request(prq_pkg::CMD_DEQUEUE, 8'h55, 8'h00, 1'b0, 0, 0);
        add_request(prq_pkg::CMD_DEQUEUE, 8'h00, 8'h00, 1'b0, 0, 0);
        add_request(prq_pkg::CMD_DEQUEUE, 8'h00, 8'h00, 1'b0, 0, 0);

        burst_left = 0;
        enq_pct = 50;
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 15);
                case ($urandom_range(2))
                    0: enq_pct = 80;
                    1: enq_pct = 20;
                    default: enq_pct = 50;
                endcase
            end
            burst_left--;
            phase = (n / 100) % 5;
            idle = (phase == 1) ? 58 : (phase == 3) ? 17 : 0;
            stall = (phase == 2) ? 58 : (phase == 3) ? 17 : 0;
            cmd = ($urandom_range(99) < enq_pct) ? prq_pkg::CMD_ENQUEUE : prq_pkg::CMD_DEQUEUE;
            add_request(cmd, 8'($urandom_range(255)), pick_priority(),
                        (n == 0 || n == 700), idle, stall);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || held_results != 0);
        repeat (16) @(negedge clk);

        if (mismatch_count == 0 && expected_responses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
